// ===== hdl/btha_pkg.sv =====
// Shared types and constants for the block table heap allocator.
package btha_pkg;

   localparam int BLOCK_SIZE = 4096;
   localparam int NUM_BLOCKS = 1024;
   localparam int BLK_SHIFT  = $clog2(BLOCK_SIZE);
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int USE_W      = $clog2(NUM_BLOCKS + 1);
   localparam int ADDR_W     = 32;
   localparam int CNT_W      = 11;
   localparam int ENTRY_W    = 3;
   localparam int NEED_W     = ADDR_W - BLK_SHIFT + 1;

   localparam logic [ENTRY_W-1:0] MARK_TAKEN = 3'b001;
   localparam logic [ENTRY_W-1:0] MARK_FIRST = 3'b010;
   localparam logic [ENTRY_W-1:0] MARK_NEXT  = 3'b100;
   localparam logic [ENTRY_W-1:0] MARK_NONE  = 3'b000;

   localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_BADADDR = 2'd2
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic {
      REG_BASE  = 1'b0,
      REG_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [CNT_W-1:0]  block_count;
   } cfg_type;

   typedef struct packed {
      action_type        action;
      logic [ADDR_W-1:0] size_bytes;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_address;
      status_type        status;
   } res_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

endpackage

// ===== hdl/btha_table_ram.sv =====
// Block table memory: one write port, one read port, registered read data.
module btha_table_ram (
   input  logic                           clock,
   input  btha_pkg::mem_req_type          mem_req,
   output logic [btha_pkg::ENTRY_W-1:0]   rdata
);

   logic [btha_pkg::ENTRY_W-1:0] mem [btha_pkg::NUM_BLOCKS];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.raddr];
   end

endmodule

// ===== hdl/btha_engine.sv =====
// Allocation sequencer: table clear, first-fit scan, run marking and free walk.
module btha_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  btha_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  btha_pkg::req_type             req,
   output logic                          res_valid,
   input  logic                          out_free,
   output btha_pkg::res_type             res,
   output btha_pkg::mem_req_type         mem_req,
   input  logic [btha_pkg::ENTRY_W-1:0]  mem_rdata
);

   typedef enum logic [5:0] {
      S_INIT = 6'b000001,
      S_IDLE = 6'b000010,
      S_SCAN = 6'b000100,
      S_MARK = 6'b001000,
      S_FREE = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic [btha_pkg::USE_W-1:0]     idx_ff, idx_in;
   logic                           pend_ff, pend_in;
   logic [btha_pkg::IDX_W-1:0]     pidx_ff, pidx_in;
   logic [btha_pkg::USE_W-1:0]     run_ff, run_in;
   logic [btha_pkg::IDX_W-1:0]     start_ff, start_in;
   logic [btha_pkg::USE_W-1:0]     need_ff, need_in;
   logic [btha_pkg::USE_W-1:0]     end_ff, end_in;
   btha_pkg::res_type              res_ff, res_in;

   logic [btha_pkg::USE_W-1:0]     in_use;
   logic [btha_pkg::NEED_W-1:0]    need_calc;
   logic [btha_pkg::ADDR_W-1:0]    offset;
   logic                           issue;
   logic [btha_pkg::IDX_W-1:0]     run_start;

   assign in_use = (32'(cfg.block_count) > 32'(btha_pkg::NUM_BLOCKS))
                   ? btha_pkg::USE_W'(btha_pkg::NUM_BLOCKS)
                   : btha_pkg::USE_W'(cfg.block_count);

   assign need_calc = btha_pkg::NEED_W'(req.size_bytes[btha_pkg::ADDR_W-1:btha_pkg::BLK_SHIFT])
                      + btha_pkg::NEED_W'(|req.size_bytes[btha_pkg::BLK_SHIFT-1:0]);
   assign offset    = req.free_address - cfg.base_address;
   assign issue     = (idx_ff < in_use);
   assign run_start = (run_ff == '0) ? pidx_ff : start_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      pidx_in  = idx_ff[btha_pkg::IDX_W-1:0];
      run_in   = run_ff;
      start_in = start_ff;
      need_in  = need_ff;
      end_in   = end_ff;
      res_in   = res_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff[btha_pkg::IDX_W-1:0];
      mem_req.wdata = btha_pkg::MARK_NONE;
      mem_req.raddr = idx_ff[btha_pkg::IDX_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_req.we = 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == btha_pkg::USE_W'(btha_pkg::NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            idx_in = '0;
            run_in = '0;
            res_in.alloc_address = '0;
            res_in.status        = btha_pkg::ST_OK;
            if (req_valid) begin
               if (req.action == btha_pkg::ACT_ALLOC) begin
                  need_in = btha_pkg::USE_W'(need_calc);
                  if (req.size_bytes == '0 || 32'(need_calc) > 32'(in_use)) begin
                     res_in.status = btha_pkg::ST_NOMEM;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  idx_in = btha_pkg::USE_W'(
                     offset[btha_pkg::BLK_SHIFT+btha_pkg::IDX_W-1:btha_pkg::BLK_SHIFT]);
                  if (offset[btha_pkg::BLK_SHIFT-1:0] != '0 ||
                      32'(offset[btha_pkg::ADDR_W-1:btha_pkg::BLK_SHIFT]) >= 32'(in_use)) begin
                     res_in.status = btha_pkg::ST_BADADDR;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               if ((mem_rdata & btha_pkg::MARK_TAKEN) != '0) begin
                  run_in = '0;
               end else begin
                  start_in = run_start;
                  run_in   = run_ff + 1'b1;
                  if (run_ff + 1'b1 == need_ff) begin
                     end_in   = btha_pkg::USE_W'(run_start) + need_ff;
                     idx_in   = btha_pkg::USE_W'(run_start);
                     pend_in  = 1'b0;
                     state_in = S_MARK;
                  end
               end
            end else if (!issue) begin
               res_in.status = btha_pkg::ST_NOMEM;
               state_in      = S_RESP;
            end
         end
         S_MARK: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = btha_pkg::MARK_TAKEN
                            | ((idx_ff == btha_pkg::USE_W'(start_ff))
                               ? btha_pkg::MARK_FIRST : btha_pkg::MARK_NONE)
                            | ((idx_ff + 1'b1 != end_ff)
                               ? btha_pkg::MARK_NEXT : btha_pkg::MARK_NONE);
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == end_ff) begin
               res_in.alloc_address = cfg.base_address
                  + (btha_pkg::ADDR_W'(start_ff) << btha_pkg::BLK_SHIFT);
               state_in = S_RESP;
            end
         end
         S_FREE: begin
            // entry i is cleared while entry i+1 is being read
            pend_in       = issue;
            mem_req.waddr = pidx_ff;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               mem_req.we = 1'b1;
               if ((mem_rdata & btha_pkg::MARK_NEXT) == '0) begin
                  pend_in  = 1'b0;
                  state_in = S_RESP;
               end
            end else if (!issue) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
      pidx_ff  <= pidx_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      need_ff  <= need_in;
      end_ff   <= end_in;
      res_ff   <= res_in;
   end

endmodule

// ===== hdl/block_table_heap_allocator_core.sv =====
// Fixed-block first-fit heap allocator: register port, stream channels, output register.
//
// Request words enter on req_* (tuser = action: 0 allocate by size, 1 free by
// address); every request gives exactly one response word on rsp_*.
// The block table (1024 entries, 3 bits) sits in one synchronous RAM with
// one read and one write port; every step of the work is one RAM access.
// Allocate: the size is checked, the table is scanned entry by entry up to
// the first fitting run, then the blocks of the run are marked one by one,
// then the result is handed over. Rejected sizes go straight to the
// response. Free: the run is released block by block.
// One request is in work at a time; req_tready is high only while the
// sequencer is idle. A finished response waits in the output register, so a
// new request is taken while rsp_tready is low; the following response waits
// in the sequencer until the output register frees up.
// After reset the table is cleared one entry a cycle: req_tready stays low
// until all of it is clear. Registers may be written at any time through
// csr_* but must only change while no request is in work.
module block_table_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // size_bytes[31:0], free_address[63:32]
   input  logic [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // alloc_address[31:0], status[33:32], zero[39:34]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   btha_pkg::cfg_type                cfg_ff, cfg_in;
   btha_pkg::req_type                req;
   btha_pkg::res_type                res;
   btha_pkg::res_type                rsp_data_ff, rsp_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             res_valid;
   logic                             out_free;
   logic                             csr_write;
   btha_pkg::mem_req_type            mem_req;
   logic [btha_pkg::ENTRY_W-1:0]     mem_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (btha_pkg::reg_index_type'(csr_paddr[2]))
            btha_pkg::REG_BASE:  cfg_in.base_address = csr_pwdata;
            btha_pkg::REG_COUNT: cfg_in.block_count  = csr_pwdata[btha_pkg::CNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (btha_pkg::reg_index_type'(csr_paddr[2]))
         btha_pkg::REG_BASE:  csr_prdata = cfg_ff.base_address;
         btha_pkg::REG_COUNT: csr_prdata = 32'(cfg_ff.block_count);
         default:             csr_prdata = '0;
      endcase
   end

   assign req.action       = btha_pkg::action_type'(req_tuser[0]);
   assign req.size_bytes   = req_tdata[31:0];
   assign req.free_address = req_tdata[63:32];

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.status, rsp_data_ff.alloc_address};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= '0;
         cfg_ff.block_count  <= btha_pkg::BLOCK_COUNT_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   btha_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .out_free  (out_free),
      .res       (res),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   btha_table_ram u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

// ===== hdl/btha_checker.sv =====
// Port-level checks for the allocator core, bound to the top level.
module btha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // table clear keeps the request side closed right after reset
   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during table clear");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3 && rsp_tdata[39:34] == 6'd0)
      else $error("undefined status code");

   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != 2'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("failed request returned an address");

endmodule

bind block_table_heap_allocator_core btha_checker u_btha_checker (.*);

// ===== tb/sv/block_table_checker.sv =====
`timescale 1ns / 1ps
// Block table checker: watches request, response and register traffic and scores responses.
module block_table_checker
   import btha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatches,
   output int          words_pending
);

   logic [ENTRY_W-1:0] heap_map [NUM_BLOCKS];
   logic [ADDR_W-1:0]  heap_base;
   logic [CNT_W-1:0]   heap_blocks;
   res_type            pending_replies [$];
   int                 fail_tally = 0;

   function automatic int usable_blocks();
      return (int'(heap_blocks) > NUM_BLOCKS) ? NUM_BLOCKS : int'(heap_blocks);
   endfunction

   // first-fit search, then chain the run
   function automatic res_type carve_run(input logic [ADDR_W-1:0] size);
      res_type     r;
      int          avail;
      int          run;
      int          start;
      bit          hit;
      logic [63:0] need;
      r.alloc_address = '0;
      r.status = ST_NOMEM;
      avail = usable_blocks();
      run = 0;
      start = 0;
      hit = 1'b0;
      if (size == '0) return r;
      need = ({32'd0, size} + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
      if (need > 64'(avail)) return r;
      for (int i = 0; i < avail; i++) begin
         if ((heap_map[i] & MARK_TAKEN) != MARK_NONE) begin
            run = 0;
         end else begin
            if (run == 0) start = i;
            run++;
            if (64'(run) == need) begin
               hit = 1'b1;
               break;
            end
         end
      end
      if (!hit) return r;
      for (int k = 0; 64'(k) < need; k++) begin
         heap_map[start + k] = MARK_TAKEN
                             | ((k == 0) ? MARK_FIRST : MARK_NONE)
                             | ((64'(k + 1) < need) ? MARK_NEXT : MARK_NONE);
      end
      r.status = ST_OK;
      r.alloc_address = heap_base + (ADDR_W'(start) << BLK_SHIFT);
      return r;
   endfunction

   // has-next is read before the entry is cleared
   function automatic res_type release_run(input logic [ADDR_W-1:0] faddr);
      res_type           r;
      int                avail;
      bit                more;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] blk;
      r.alloc_address = '0;
      r.status = ST_BADADDR;
      avail = usable_blocks();
      offset = faddr - heap_base;
      if (offset[BLK_SHIFT-1:0] != '0) return r;
      blk = offset >> BLK_SHIFT;
      if (blk >= ADDR_W'(avail)) return r;
      for (int i = int'(blk); i < avail; i++) begin
         more = (heap_map[i] & MARK_NEXT) != MARK_NONE;
         heap_map[i] = MARK_NONE;
         if (!more) break;
      end
      r.status = ST_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      res_type           want;
      req_type           rq;
      logic [ADDR_W-1:0] got_addr;
      status_type        got_status;
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) heap_map[i] = MARK_NONE;
         heap_base = '0;
         heap_blocks = BLOCK_COUNT_RESET;
         pending_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_addr = rsp_tdata[31:0];
            got_status = status_type'(rsp_tdata[33:32]);
            if (pending_replies.size() == 0) begin
               $error("response word with nothing expected: alloc_address %h status %0d",
                      got_addr, got_status);
               fail_tally++;
            end else begin
               want = pending_replies.pop_front();
               if (got_addr !== want.alloc_address) begin
                  $error("alloc_address: expected %h, got %h", want.alloc_address, got_addr);
                  fail_tally++;
               end
               if (got_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got_status);
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq.action = action_type'(req_tuser[0]);
            rq.size_bytes = req_tdata[31:0];
            rq.free_address = req_tdata[63:32];
            if (rq.action == ACT_ALLOC) pending_replies.push_back(carve_run(rq.size_bytes));
            else pending_replies.push_back(release_run(rq.free_address));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_BASE: heap_base = csr_pwdata;
               REG_COUNT: heap_blocks = csr_pwdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
      mismatches <= fail_tally;
      words_pending <= pending_replies.size();
   end

endmodule

// ===== tb/sv/tb_block_table_heap_allocator_core.sv =====
`timescale 1ns / 1ps
// Top testbench for the block table heap allocator: stimulus, flow control and verdict.
module tb_block_table_heap_allocator_core;
   import btha_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // size_bytes[31:0], free_address[63:32]
   logic [0:0]  req_tuser = '0;   // action[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // alloc_address[31:0], status[33:32]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          words_pending;
   int          stall_cycles = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   logic [31:0] cur_base = '0;
   int          cur_blocks = 1024;
   logic [31:0] live_runs [$];
   action_type  sent_kinds [$];

   always #6 clock = ~clock;

   block_table_heap_allocator_core uut (.*);

   block_table_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("** block_table_heap_allocator_core: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // keep addresses of successful allocations so frees can target real runs
   always @(posedge clock) begin
      action_type kind;
      if (!reset && rsp_tvalid && rsp_tready && sent_kinds.size() != 0) begin
         kind = sent_kinds.pop_front();
         if (kind == ACT_ALLOC && status_type'(rsp_tdata[33:32]) == ST_OK)
            live_runs.push_back(rsp_tdata[31:0]);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 6);
         end
      end
   end

   task automatic send_word(input action_type act, input logic [31:0] size,
                            input logic [31:0] faddr);
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {faddr, size};
      req_tuser <= act;
      do @(posedge clock); while (!req_tready);
      sent_kinds.push_back(act);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_heap(input logic [31:0] base, input int count);
      drain();
      write_reg(REG_BASE, base);
      write_reg(REG_COUNT, 32'(count));
      cur_base = base;
      cur_blocks = count;
      live_runs.delete();
   endtask

   task automatic random_item();
      int          avail;
      int          cap;
      int          pick;
      int          slot;
      int          blk;
      logic [31:0] addr;
      avail = (cur_blocks > NUM_BLOCKS) ? NUM_BLOCKS : cur_blocks;
      cap = (avail < 8) ? avail : ((avail / 4 > 24) ? 24 : avail / 4);
      if (cap == 0) cap = 1;
      pick = $urandom_range(0, 99);
      if (pick < 85 && (pick < 55 || live_runs.size() == 0)) begin
         if ($urandom_range(0, 7) == 0)
            send_word(ACT_ALLOC, $urandom_range(1, (avail + 1) * BLOCK_SIZE), $urandom());
         else
            send_word(ACT_ALLOC, $urandom_range(1, cap * BLOCK_SIZE), $urandom());
      end else if (pick < 85) begin
         slot = $urandom_range(0, live_runs.size() - 1);
         addr = live_runs[slot];
         live_runs.delete(slot);
         send_word(ACT_FREE, $urandom(), addr);
      end else begin
         case ($urandom_range(0, 4))
            0: send_word(ACT_ALLOC, $urandom(), $urandom());
            1: send_word(ACT_ALLOC, 32'd0, $urandom());
            2: send_word(ACT_FREE, $urandom(), $urandom());
            3: begin
               blk = $urandom_range(0, avail + 2);
               send_word(ACT_FREE, $urandom(), cur_base + (32'(blk) << BLK_SHIFT));
            end
            default: send_word(ACT_FREE, $urandom(), cur_base + $urandom_range(1, BLOCK_SIZE - 1));
         endcase
      end
   endtask

   task automatic random_phase(input logic [31:0] base, input int count, input int n,
                               input bit quiet, input bit squeeze);
      set_heap(base, count);
      calm = quiet;
      if (squeeze) hold_request = 1'b1;
      repeat (n) random_item();
   endtask

   initial begin
      logic [31:0] hb;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      hb = 32'h1000_0000;
      set_heap(hb, 1024);

      send_word(ACT_ALLOC, 32'd0, 32'hFFFF_FFFF);
      send_word(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_word(ACT_ALLOC, 32'd1, 32'd0);
      send_word(ACT_ALLOC, 32'd4096, 32'd0);
      send_word(ACT_ALLOC, 32'd4097, 32'd0);
      send_word(ACT_ALLOC, 32'h0040_0000, 32'd0);
      send_word(ACT_ALLOC, 32'h003F_C000, 32'd0);
      send_word(ACT_ALLOC, 32'd1, 32'd0);
      send_word(ACT_FREE, 32'd0, hb + 32'd1);
      send_word(ACT_FREE, 32'd0, hb + 32'h0040_0000);
      send_word(ACT_FREE, 32'hFFFF_FFFF, hb - 32'd4096);
      send_word(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACT_FREE, 32'd0, hb + 32'h2000);
      send_word(ACT_FREE, 32'd0, hb + 32'h3000);
      send_word(ACT_FREE, 32'd0, hb + 32'h5000);
      send_word(ACT_ALLOC, 32'h3000, 32'hFFFF_FFFF);
      send_word(ACT_FREE, 32'hFFFF_FFFF, hb + 32'h4000);
      send_word(ACT_FREE, 32'd0, hb);
      send_word(ACT_FREE, 32'd0, hb + 32'h1000);
      send_word(ACT_ALLOC, 32'h0040_0000, 32'd0);
      send_word(ACT_FREE, 32'd0, hb);

      random_phase(32'hFFFF_C000, 8, 50, 1'b0, 1'b0);
      random_phase(32'h0000_0000, 1024, 40, 1'b0, 1'b1);
      random_phase(32'h8000_0000, 64, 60, 1'b0, 1'b0);
      random_phase(32'h0000_0000, 0, 10, 1'b0, 1'b0);
      random_phase(32'h7FFF_F000, 2047, 40, 1'b0, 1'b0);
      random_phase(32'h0004_0000, 1, 20, 1'b0, 1'b0);
      random_phase(32'hFFFF_F000, 16, 60, 1'b1, 1'b0);
      calm = 1'b0;
      drain();

      if (mismatches == 0) begin
         $display("** block_table_heap_allocator_core: PASSED **");
      end else begin
         $display("** block_table_heap_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule
